### rtl/pls_pkg.sv
// Package for the packet link scheduler.
// Holds the phase, operation, action, origin and register codes, reset values
// and the structs shared by the step logic and the top level. No dependencies.
package pls_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SYNC     = 3'd1,
    PH_GAP      = 3'd2,
    PH_DATA     = 3'd3,
    PH_RECOVERY = 3'd4
  } phase_e;

  localparam logic [1:0] OP_STEP    = 2'd0;
  localparam logic [1:0] OP_INIT    = 2'd1;
  localparam logic [1:0] OP_RECOVER = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_SYNC = 2'd1;
  localparam logic [1:0] ACT_DATA = 2'd2;

  localparam logic [1:0] ORG_SYNC_TIMEOUT = 2'd0;
  localparam logic [1:0] ORG_DEADLINE     = 2'd1;
  localparam logic [1:0] ORG_DATA_TIMEOUT = 2'd2;
  localparam logic [1:0] ORG_BAD_STATE    = 2'd3;

  localparam logic [2:0] REG_PACKET_PERIOD   = 3'd0;
  localparam logic [2:0] REG_IDLE_MINIMUM    = 3'd1;
  localparam logic [2:0] REG_SYNC_TIMEOUT    = 3'd2;
  localparam logic [2:0] REG_SYNC_GAP        = 3'd3;
  localparam logic [2:0] REG_DATA_DEADLINE   = 3'd4;
  localparam logic [2:0] REG_DATA_TIMEOUT    = 3'd5;
  localparam logic [2:0] REG_NO_READING_CODE = 3'd6;

  localparam logic [15:0] RST_PACKET_PERIOD   = 16'd100;
  localparam logic [15:0] RST_IDLE_MINIMUM    = 16'd10;
  localparam logic [15:0] RST_SYNC_TIMEOUT    = 16'd5;
  localparam logic [15:0] RST_SYNC_GAP        = 16'd1;
  localparam logic [15:0] RST_DATA_DEADLINE   = 16'd8;
  localparam logic [15:0] RST_DATA_TIMEOUT    = 16'd5;
  localparam logic [15:0] RST_NO_READING_CODE = 16'd65528;

  localparam logic [31:0] RST_SYNC_TICK  = 32'd0 - {16'd0, RST_PACKET_PERIOD};
  localparam logic [31:0] RST_QUIET_TICK = 32'd0 - {16'd0, RST_IDLE_MINIMUM} - 32'd1;

  localparam logic [15:0] CNT16_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] packet_period;
    logic [15:0] idle_minimum;
    logic [15:0] sync_timeout;
    logic [15:0] sync_gap;
    logic [15:0] data_deadline;
    logic [15:0] data_timeout;
    logic [15:0] no_reading_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now;
    logic        held;
    logic        link_mode;
    logic        tx_idle;
    logic        tx_done;
    logic [31:0] done_tick;
    logic [15:0] cur_code;
    logic [1:0]  abort_origin;
  } item_t;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] last_sync_tick;
    logic [31:0] quiet_reference;
    logic [31:0] sync_start_tick;
    logic [31:0] last_done_tick;
    logic [15:0] latched_code;
    logic [31:0] sent_count;
    logic [15:0] skip_count;
  } track_t;

  typedef struct packed {
    logic       clear;
    logic       bump;
    logic [1:0] origin;
  } abort_t;

endpackage

### rtl/packet_link_scheduler.sv
// Top level of the packet link scheduler: input register, configuration registers,
// link state and abort counters, result register. Depends on pls_pkg and pls_step.
//
//   channel  direction  handshake                 payload
//   in       in         in_valid_i / in_stall_o   operation_i .. abort_origin_i
//   out      out        out_valid_o / out_stall_i action_o .. bad_state_aborts_o
//   cfg      in         cfg_we_i                  cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while the output is not stalled; a beat held in the input
// register passes the step logic into the state and result registers once the output
// is free to take it, and its result is then valid. Reset clears the link state as an
// init at tick 0 with the reset register values. A stalled output holds the result
// and the state, and the input register takes one more beat before stalling the input side.
module packet_link_scheduler #(
  parameter int ABORT_KINDS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] now_i,
  input  logic        held_i,
  input  logic        link_mode_i,
  input  logic        tx_idle_i,
  input  logic        tx_done_i,
  input  logic [31:0] done_tick_i,
  input  logic [15:0] cur_code_i,
  input  logic [1:0]  abort_origin_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [7:0]  frame_high_o,
  output logic [7:0]  frame_low_o,
  output logic [7:0]  frame_check_o,
  output logic        in_packet_o,
  output logic [31:0] packets_sent_o,
  output logic [15:0] busy_skip_count_o,
  output logic [15:0] sync_timeout_aborts_o,
  output logic [15:0] deadline_aborts_o,
  output logic [15:0] data_timeout_aborts_o,
  output logic [15:0] bad_state_aborts_o
);

  localparam int AW = (ABORT_KINDS > 1) ? $clog2(ABORT_KINDS) : 1;

  pls_pkg::cfg_t   cfg_q;
  pls_pkg::item_t  item_q;
  logic            in_valid_q;
  logic            out_valid_q;
  logic [1:0]      action_q;
  pls_pkg::track_t track_q;
  pls_pkg::track_t track_d;
  logic [1:0]      action_d;
  pls_pkg::abort_t abort;
  logic [15:0]     abort_cnt_q [ABORT_KINDS];
  logic [AW-1:0]   abort_idx;
  logic            advance;
  logic            take_in;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign take_in    = in_valid_i && !in_stall_o;
  assign in_stall_o = in_valid_q && !advance;
  assign abort_idx  = AW'(abort.origin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.packet_period   <= pls_pkg::RST_PACKET_PERIOD;
      cfg_q.idle_minimum    <= pls_pkg::RST_IDLE_MINIMUM;
      cfg_q.sync_timeout    <= pls_pkg::RST_SYNC_TIMEOUT;
      cfg_q.sync_gap        <= pls_pkg::RST_SYNC_GAP;
      cfg_q.data_deadline   <= pls_pkg::RST_DATA_DEADLINE;
      cfg_q.data_timeout    <= pls_pkg::RST_DATA_TIMEOUT;
      cfg_q.no_reading_code <= pls_pkg::RST_NO_READING_CODE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pls_pkg::REG_PACKET_PERIOD:   cfg_q.packet_period   <= cfg_data_i;
        pls_pkg::REG_IDLE_MINIMUM:    cfg_q.idle_minimum    <= cfg_data_i;
        pls_pkg::REG_SYNC_TIMEOUT:    cfg_q.sync_timeout    <= cfg_data_i;
        pls_pkg::REG_SYNC_GAP:        cfg_q.sync_gap        <= cfg_data_i;
        pls_pkg::REG_DATA_DEADLINE:   cfg_q.data_deadline   <= cfg_data_i;
        pls_pkg::REG_DATA_TIMEOUT:    cfg_q.data_timeout    <= cfg_data_i;
        pls_pkg::REG_NO_READING_CODE: cfg_q.no_reading_code <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take_in) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      item_q.operation    <= operation_i;
      item_q.now          <= now_i;
      item_q.held         <= held_i;
      item_q.link_mode    <= link_mode_i;
      item_q.tx_idle      <= tx_idle_i;
      item_q.tx_done      <= tx_done_i;
      item_q.done_tick    <= done_tick_i;
      item_q.cur_code     <= cur_code_i;
      item_q.abort_origin <= abort_origin_i;
    end
  end

  pls_step u_step (
    .cfg_i    (cfg_q),
    .track_i  (track_q),
    .item_i   (item_q),
    .track_o  (track_d),
    .action_o (action_d),
    .abort_o  (abort)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q.phase           <= pls_pkg::PH_IDLE;
      track_q.last_sync_tick  <= pls_pkg::RST_SYNC_TICK;
      track_q.sync_start_tick <= pls_pkg::RST_SYNC_TICK;
      track_q.quiet_reference <= pls_pkg::RST_QUIET_TICK;
      track_q.last_done_tick  <= pls_pkg::RST_QUIET_TICK;
      track_q.latched_code    <= pls_pkg::RST_NO_READING_CODE;
      track_q.sent_count      <= 32'd0;
      track_q.skip_count      <= 16'd0;
    end else if (advance) begin
      track_q <= track_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ABORT_KINDS; k++) begin
        abort_cnt_q[k] <= 16'd0;
      end
    end else if (advance) begin
      if (abort.clear) begin
        for (int k = 0; k < ABORT_KINDS; k++) begin
          abort_cnt_q[k] <= 16'd0;
        end
      end else if (abort.bump && (abort_cnt_q[abort_idx] != pls_pkg::CNT16_MAX)) begin
        abort_cnt_q[abort_idx] <= abort_cnt_q[abort_idx] + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      action_q <= action_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign action_o              = action_q;
  assign frame_high_o          = track_q.latched_code[15:8];
  assign frame_low_o           = track_q.latched_code[7:0];
  assign frame_check_o         = ~(track_q.latched_code[15:8] + track_q.latched_code[7:0]);
  assign in_packet_o           = (track_q.phase == pls_pkg::PH_SYNC) ||
                                 (track_q.phase == pls_pkg::PH_GAP) ||
                                 (track_q.phase == pls_pkg::PH_DATA);
  assign packets_sent_o        = track_q.sent_count;
  assign busy_skip_count_o     = track_q.skip_count;
  assign sync_timeout_aborts_o = abort_cnt_q[AW'(pls_pkg::ORG_SYNC_TIMEOUT)];
  assign deadline_aborts_o     = abort_cnt_q[AW'(pls_pkg::ORG_DEADLINE)];
  assign data_timeout_aborts_o = abort_cnt_q[AW'(pls_pkg::ORG_DATA_TIMEOUT)];
  assign bad_state_aborts_o    = abort_cnt_q[AW'(pls_pkg::ORG_BAD_STATE)];

endmodule

### rtl/pls_step.sv
// Next-state logic of the packet link scheduler for one beat.
// Depends on pls_pkg for the codes and the cfg_t, item_t, track_t and abort_t structs.
module pls_step (
  input  pls_pkg::cfg_t   cfg_i,
  input  pls_pkg::track_t track_i,
  input  pls_pkg::item_t  item_i,
  output pls_pkg::track_t track_o,
  output logic [1:0]      action_o,
  output pls_pkg::abort_t abort_o
);

  logic [31:0] since_sync;
  logic [31:0] since_quiet;
  logic [31:0] since_start;
  logic [31:0] since_done;
  logic [16:0] quiet_limit;
  logic [16:0] data_limit;
  logic        quiet_ok;
  logic        start_ok;

  assign since_sync  = item_i.now - track_i.last_sync_tick;
  assign since_quiet = item_i.now - track_i.quiet_reference;
  assign since_start = item_i.now - track_i.sync_start_tick;
  assign since_done  = item_i.now - track_i.last_done_tick;
  assign quiet_limit = {1'b0, cfg_i.idle_minimum} + 17'd1;
  assign data_limit  = {1'b0, cfg_i.data_deadline} + {1'b0, cfg_i.data_timeout};
  assign quiet_ok    = since_quiet >= {15'd0, quiet_limit};
  assign start_ok    = (since_sync >= {16'd0, cfg_i.packet_period}) && quiet_ok &&
                       !item_i.held && item_i.link_mode;

  always_comb begin
    track_o  = track_i;
    action_o = pls_pkg::ACT_NONE;
    abort_o  = '{clear: 1'b0, bump: 1'b0, origin: pls_pkg::ORG_SYNC_TIMEOUT};
    case (item_i.operation)
      pls_pkg::OP_STEP: begin
        case (track_i.phase)
          pls_pkg::PH_IDLE: begin
            if (start_ok) begin
              if (!item_i.tx_idle) begin
                if (track_i.skip_count != pls_pkg::CNT16_MAX) begin
                  track_o.skip_count = track_i.skip_count + 16'd1;
                end
              end else begin
                track_o.latched_code    = item_i.cur_code;
                track_o.sync_start_tick = item_i.now;
                track_o.last_sync_tick  = item_i.now;
                track_o.phase           = pls_pkg::PH_SYNC;
                action_o                = pls_pkg::ACT_SYNC;
              end
            end
          end
          pls_pkg::PH_SYNC: begin
            if (item_i.tx_done) begin
              track_o.last_done_tick = item_i.done_tick;
              track_o.phase          = pls_pkg::PH_GAP;
            end else if (since_start >= {16'd0, cfg_i.sync_timeout}) begin
              abort_o.bump            = 1'b1;
              abort_o.origin          = pls_pkg::ORG_SYNC_TIMEOUT;
              track_o.quiet_reference = item_i.now;
              track_o.phase           = pls_pkg::PH_RECOVERY;
            end
          end
          pls_pkg::PH_GAP: begin
            if (since_done >= {16'd0, cfg_i.sync_gap}) begin
              if (since_start <= {16'd0, cfg_i.data_deadline}) begin
                track_o.phase = pls_pkg::PH_DATA;
                action_o      = pls_pkg::ACT_DATA;
              end else begin
                abort_o.bump            = 1'b1;
                abort_o.origin          = pls_pkg::ORG_DEADLINE;
                track_o.quiet_reference = item_i.now;
                track_o.phase           = pls_pkg::PH_RECOVERY;
              end
            end
          end
          pls_pkg::PH_DATA: begin
            if (item_i.tx_done) begin
              track_o.last_done_tick  = item_i.done_tick;
              track_o.quiet_reference = item_i.done_tick;
              track_o.sent_count      = track_i.sent_count + 32'd1;
              track_o.phase           = pls_pkg::PH_IDLE;
            end else if (since_start >= {15'd0, data_limit}) begin
              abort_o.bump            = 1'b1;
              abort_o.origin          = pls_pkg::ORG_DATA_TIMEOUT;
              track_o.quiet_reference = item_i.now;
              track_o.phase           = pls_pkg::PH_RECOVERY;
            end
          end
          pls_pkg::PH_RECOVERY: begin
            if (quiet_ok && item_i.tx_idle) begin
              track_o.phase = pls_pkg::PH_IDLE;
            end
          end
          default: begin
            abort_o.bump            = 1'b1;
            abort_o.origin          = pls_pkg::ORG_BAD_STATE;
            track_o.quiet_reference = item_i.now;
            track_o.phase           = pls_pkg::PH_RECOVERY;
          end
        endcase
      end
      pls_pkg::OP_INIT: begin
        track_o.phase           = pls_pkg::PH_IDLE;
        track_o.last_sync_tick  = item_i.now - {16'd0, cfg_i.packet_period};
        track_o.sync_start_tick = item_i.now - {16'd0, cfg_i.packet_period};
        track_o.quiet_reference = item_i.now - {15'd0, quiet_limit};
        track_o.last_done_tick  = item_i.now - {15'd0, quiet_limit};
        track_o.latched_code    = cfg_i.no_reading_code;
        track_o.sent_count      = 32'd0;
        track_o.skip_count      = 16'd0;
        abort_o.clear           = 1'b1;
      end
      pls_pkg::OP_RECOVER: begin
        abort_o.bump            = 1'b1;
        abort_o.origin          = item_i.abort_origin;
        track_o.quiet_reference = item_i.now;
        track_o.phase           = pls_pkg::PH_RECOVERY;
      end
      default: begin
      end
    endcase
  end

endmodule
